/* sv/rpw_pkg.sv */
// shared constants, types and helpers for the rgb pack pixel writer
`default_nettype none
package rpw_pkg;

	localparam int CfgW       = 15;
	localparam int CfgIdxW    = 3;
	localparam int CoordW     = 16;
	localparam int DimW       = 13;
	localparam int PitchW     = 15;
	localparam int PbW        = 3;
	localparam int LayoutW    = 10;
	localparam int ColorW     = 32;
	localparam int OffsetW    = 27;
	localparam int BeW        = 4;
	localparam int ChanW      = 8;
	localparam int ProdW      = 24;
	localparam int QuotW      = 17;
	localparam int ScaledW    = 16;

	// rounding term and reciprocal of 255 for the channel scaling
	localparam logic [ProdW-1:0] RND_ADD     = 24'd127;
	localparam logic [15:0]      RECIP_255   = 16'd32897;
	localparam int               RECIP_SHIFT = 23;
	localparam logic [7:0]       CHAN_MAX    = 8'd255;
	localparam logic [4:0]       SIZE_MAX    = 5'd16;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_ACTIVE_WIDTH  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ACTIVE_HEIGHT = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ROW_PITCH     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PIXEL_BYTES   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RED_LAYOUT    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_GREEN_LAYOUT  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_BLUE_LAYOUT   = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_DOUBLE_BUF    = 3'd7;

	localparam logic [PbW-1:0] PB_TWO   = 3'd2;
	localparam logic [PbW-1:0] PB_THREE = 3'd3;
	localparam logic [PbW-1:0] PB_FOUR  = 3'd4;

	localparam logic [BeW-1:0] BE_TWO   = 4'h3;
	localparam logic [BeW-1:0] BE_THREE = 4'h7;
	localparam logic [BeW-1:0] BE_FOUR  = 4'hF;

	// per-stage load enables handed to the datapath modules
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

	function automatic logic [PbW-1:0] clamp_bytes(input logic [PbW-1:0] pb);
		logic [PbW-1:0] r;
		r = pb;
		if (pb < PB_TWO)
			r = PB_TWO;
		else if (pb > PB_FOUR)
			r = PB_FOUR;
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/rpw_if.sv */
// valid/ready channels for pixel requests and framebuffer writes
`default_nettype none
interface rpw_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] x_pos;
	logic [15:0] y_pos;
	logic        packed_given;
	logic [31:0] packed_color;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;

	modport source (output valid, x_pos, y_pos, packed_given, packed_color,
		red_in, green_in, blue_in, input ready);
	modport sink (input valid, x_pos, y_pos, packed_given, packed_color,
		red_in, green_in, blue_in, output ready);
endinterface

interface rpw_out_if;
	logic        valid;
	logic        ready;
	logic        inside_res;
	logic        to_back_buffer;
	logic [26:0] byte_offset;
	logic [31:0] write_data;
	logic [3:0]  byte_enable;
	logic [31:0] pixel_color;

	modport source (output valid, inside_res, to_back_buffer, byte_offset,
		write_data, byte_enable, pixel_color, input ready);
	modport sink (input valid, inside_res, to_back_buffer, byte_offset,
		write_data, byte_enable, pixel_color, output ready);
endinterface
`default_nettype wire

/* sv/rpw_chan_scale.sv */
// one colour channel: scale 8 bits to the mask size with rounding, then place it
`default_nettype none
module rpw_chan_scale
	import rpw_pkg::*;
(
	input  wire logic                 clk,
	input  wire adv_t                 adv,
	input  wire logic [ChanW-1:0]     chan,
	input  wire logic [LayoutW-1:0]   layout,
	output logic      [ColorW-1:0]    placed
);

	logic [4:0]          size_c;
	logic [ScaledW-1:0]  maxv_c;
	logic [ProdW-1:0]    prod_c;
	logic [39:0]         recip_c;
	logic [25:0]         diff_c;
	logic [ScaledW-1:0]  quot_c;

	logic [ProdW-1:0]    prod_s1;
	logic [4:0]          pos_s1;
	logic [ProdW-1:0]    prod_s2;
	logic [QuotW-1:0]    q0_s2;
	logic [4:0]          pos_s2;

	always_comb begin
		size_c = (layout[9:5] > SIZE_MAX) ? SIZE_MAX : layout[9:5];
		maxv_c = ScaledW'((17'd1 << size_c) - 17'd1);
		prod_c = ProdW'({16'd0, chan}) * ProdW'(maxv_c) + RND_ADD;
	end

	// estimate of prod/255 by reciprocal, may be one too high
	assign recip_c = 40'(prod_s1) * 40'(RECIP_255);

	always_comb begin
		diff_c = 26'(prod_s2) - 26'(q0_s2) * 26'(CHAN_MAX);
		quot_c = diff_c[25] ? ScaledW'(q0_s2 - 17'd1) : ScaledW'(q0_s2);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			prod_s1 <= prod_c;
			pos_s1  <= layout[4:0];
		end
		if (adv.s2) begin
			prod_s2 <= prod_s1;
			q0_s2   <= QuotW'(recip_c >> RECIP_SHIFT);
			pos_s2  <= pos_s1;
		end
		if (adv.s3) begin
			placed <= ColorW'(quot_c) << pos_s2;
		end
	end

endmodule
`default_nettype wire

/* sv/rpw_addr_gen.sv */
// clip test and byte offset y*pitch + x*bytes
`default_nettype none
module rpw_addr_gen
	import rpw_pkg::*;
(
	input  wire logic                 clk,
	input  wire adv_t                 adv,
	input  wire logic [CoordW-1:0]    x_pos,
	input  wire logic [CoordW-1:0]    y_pos,
	input  wire logic [DimW-1:0]      active_width,
	input  wire logic [DimW-1:0]      active_height,
	input  wire logic [PitchW-1:0]    row_pitch,
	input  wire logic [PbW-1:0]       nbytes,
	output logic                      on_screen,
	output logic      [OffsetW-1:0]   byte_offset
);

	logic [30:0]         ymul_s1;
	logic [18:0]         xmul_s1;
	logic                inside_s1;
	logic [OffsetW-1:0]  sum_s2;
	logic                inside_s2;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			ymul_s1   <= 31'(y_pos) * 31'(row_pitch);
			xmul_s1   <= 19'(x_pos) * 19'(nbytes);
			inside_s1 <= (x_pos < CoordW'(active_width)) &&
				(y_pos < CoordW'(active_height));
		end
		if (adv.s2) begin
			// offset wraps to its width
			sum_s2    <= OffsetW'(ymul_s1) + OffsetW'(xmul_s1);
			inside_s2 <= inside_s1;
		end
		if (adv.s3) begin
			byte_offset <= sum_s2;
			on_screen   <= inside_s2;
		end
	end

endmodule
`default_nettype wire

/* sv/rgb_pack_pixel_writer_core.sv */
// Pixel writer core: turns a pixel request (x, y and either 8-bit red/green/blue or a
// packed colour) into one framebuffer write of offset, data and byte enables. It is a
// four-stage pipeline: multiply (channel scale and row offset), reciprocal divide by 255,
// rounding correction with channel placement, and an output register that packs the word.
// A request can be accepted every cycle unless the pipeline stalls; results leave in
// order and stalls hold in place stage by stage. Every request yields exactly one
// write word, with inside_res low and the write fields zero when the pixel is clipped.
// Users must write configuration registers only while no request is in flight; unenforced.
`default_nettype none
module rgb_pack_pixel_writer_core
	import rpw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIdxW-1:0]   cfg_index,
	input  wire logic [CfgW-1:0]      cfg_data,
	rpw_in_if.sink                    pix_in,
	rpw_out_if.source                 pix_out
);

	logic [DimW-1:0]     active_width_q;
	logic [DimW-1:0]     active_height_q;
	logic [PitchW-1:0]   row_pitch_q;
	logic [PbW-1:0]      pixel_bytes_q;
	logic [LayoutW-1:0]  red_layout_q;
	logic [LayoutW-1:0]  green_layout_q;
	logic [LayoutW-1:0]  blue_layout_q;
	logic                double_buffer_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	adv_t adv;

	logic                given_s1, given_s2, given_s3;
	logic [ColorW-1:0]   pcol_s1, pcol_s2, pcol_s3;
	logic [PbW-1:0]      nb_s1, nb_s2, nb_s3;
	logic                db_s1, db_s2, db_s3;

	logic [ColorW-1:0]   red_pl, green_pl, blue_pl;
	logic                inside_s3;
	logic [OffsetW-1:0]  offset_s3;
	logic [ColorW-1:0]   color_c;
	logic [ColorW-1:0]   wdata_c;
	logic [BeW-1:0]      be_c;

	logic                inside_s4;
	logic                db_s4;
	logic [OffsetW-1:0]  offset_s4;
	logic [ColorW-1:0]   wdata_s4;
	logic [BeW-1:0]      be_s4;
	logic [ColorW-1:0]   color_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q  <= '0;
			active_height_q <= '0;
			row_pitch_q     <= '0;
			pixel_bytes_q   <= PB_FOUR;
			red_layout_q    <= '0;
			green_layout_q  <= '0;
			blue_layout_q   <= '0;
			double_buffer_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_WIDTH:  active_width_q  <= cfg_data[DimW-1:0];
				REG_ACTIVE_HEIGHT: active_height_q <= cfg_data[DimW-1:0];
				REG_ROW_PITCH:     row_pitch_q     <= cfg_data[PitchW-1:0];
				REG_PIXEL_BYTES:   pixel_bytes_q   <= cfg_data[PbW-1:0];
				REG_RED_LAYOUT:    red_layout_q    <= cfg_data[LayoutW-1:0];
				REG_GREEN_LAYOUT:  green_layout_q  <= cfg_data[LayoutW-1:0];
				REG_BLUE_LAYOUT:   blue_layout_q   <= cfg_data[LayoutW-1:0];
				REG_DOUBLE_BUF:    double_buffer_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// each stage loads when it is empty or its successor moves
	assign rdy4   = !v_s4 || pix_out.ready;
	assign rdy3   = !v_s3 || rdy4;
	assign rdy2   = !v_s2 || rdy3;
	assign rdy1   = !v_s1 || rdy2;
	assign adv.s1 = rdy1;
	assign adv.s2 = rdy2;
	assign adv.s3 = rdy3;
	assign pix_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix_in.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			given_s1 <= pix_in.packed_given;
			pcol_s1  <= pix_in.packed_color;
			nb_s1    <= clamp_bytes(pixel_bytes_q);
			db_s1    <= double_buffer_q;
		end
		if (rdy2) begin
			given_s2 <= given_s1;
			pcol_s2  <= pcol_s1;
			nb_s2    <= nb_s1;
			db_s2    <= db_s1;
		end
		if (rdy3) begin
			given_s3 <= given_s2;
			pcol_s3  <= pcol_s2;
			nb_s3    <= nb_s2;
			db_s3    <= db_s2;
		end
	end

	rpw_chan_scale u_red (
		.clk    (clk),
		.adv    (adv),
		.chan   (pix_in.red_in),
		.layout (red_layout_q),
		.placed (red_pl)
	);

	rpw_chan_scale u_green (
		.clk    (clk),
		.adv    (adv),
		.chan   (pix_in.green_in),
		.layout (green_layout_q),
		.placed (green_pl)
	);

	rpw_chan_scale u_blue (
		.clk    (clk),
		.adv    (adv),
		.chan   (pix_in.blue_in),
		.layout (blue_layout_q),
		.placed (blue_pl)
	);

	rpw_addr_gen u_addr (
		.clk           (clk),
		.adv           (adv),
		.x_pos         (pix_in.x_pos),
		.y_pos         (pix_in.y_pos),
		.active_width  (active_width_q),
		.active_height (active_height_q),
		.row_pitch     (row_pitch_q),
		.nbytes        (clamp_bytes(pixel_bytes_q)),
		.on_screen     (inside_s3),
		.byte_offset   (offset_s3)
	);

	always_comb begin
		color_c = given_s3 ? pcol_s3 : (red_pl | green_pl | blue_pl);
		case (nb_s3)
			PB_TWO: begin
				wdata_c = {16'd0, color_c[15:0]};
				be_c    = BE_TWO;
			end
			PB_THREE: begin
				wdata_c = {8'd0, color_c[23:0]};
				be_c    = BE_THREE;
			end
			default: begin
				wdata_c = color_c;
				be_c    = BE_FOUR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			inside_s4 <= inside_s3;
			db_s4     <= inside_s3 & db_s3;
			offset_s4 <= inside_s3 ? offset_s3 : '0;
			wdata_s4  <= inside_s3 ? wdata_c : '0;
			be_s4     <= inside_s3 ? be_c : '0;
			color_s4  <= color_c;
		end
	end

	assign pix_out.valid          = v_s4;
	assign pix_out.inside_res     = inside_s4;
	assign pix_out.to_back_buffer = db_s4;
	assign pix_out.byte_offset    = offset_s4;
	assign pix_out.write_data     = wdata_s4;
	assign pix_out.byte_enable    = be_s4;
	assign pix_out.pixel_color    = color_s4;

endmodule
`default_nettype wire

/* sv/rpw_checker.sv */
// port-level checks on the pixel writer core, bound to the top level
`default_nettype none
module rpw_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        inside_res,
	input  wire logic        to_back_buffer,
	input  wire logic [26:0] byte_offset,
	input  wire logic [31:0] write_data,
	input  wire logic [3:0]  byte_enable,
	input  wire logic [31:0] pixel_color
);

	// a clipped word carries no write
	a_clip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> byte_enable == 4'h0 && byte_offset == 27'd0 &&
			write_data == 32'd0 && !to_back_buffer)
		else $error("clipped word carries write fields");

	a_be_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_res |->
			byte_enable == 4'h3 || byte_enable == 4'h7 || byte_enable == 4'hF)
		else $error("illegal byte enable");

	// data beyond the enabled lanes stays zero
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_res && byte_enable != 4'hF |-> write_data[31:24] == 8'd0 &&
			(byte_enable != 4'h3 || write_data[23:16] == 8'd0))
		else $error("data outside enabled lanes");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_color) &&
			$stable(byte_offset))
		else $error("stalled word changed");

endmodule

bind rgb_pack_pixel_writer_core rpw_checker u_rpw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (pix_out.valid),
	.out_ready      (pix_out.ready),
	.inside_res     (pix_out.inside_res),
	.to_back_buffer (pix_out.to_back_buffer),
	.byte_offset    (pix_out.byte_offset),
	.write_data     (pix_out.write_data),
	.byte_enable    (pix_out.byte_enable),
	.pixel_color    (pix_out.pixel_color)
);
`default_nettype wire

/* sim/tb_top.sv */
// self-checking bench for the pixel writer: own predictor, random config and traffic
`default_nettype none
module tb_top;
	import rpw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		logic        packed_given;
		logic [31:0] packed_color;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} pixel_req_t;

	typedef struct {
		logic        on_screen;
		logic        back;
		logic [26:0] offset;
		logic [31:0] data;
		logic [3:0]  be;
		logic [31:0] color;
	} fb_write_t;

	typedef struct {
		logic [12:0] width;
		logic [12:0] height;
		logic [14:0] pitch;
		logic [2:0]  pbytes;
		logic [9:0]  red;
		logic [9:0]  green;
		logic [9:0]  blue;
		logic        dbuf;
	} fb_cfg_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [CfgW-1:0]      cfg_data;

	rpw_in_if  pix_in ();
	rpw_out_if pix_out ();

	rgb_pack_pixel_writer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in),
		.pix_out   (pix_out)
	);

	// predictor copy of the register file
	fb_cfg_t   fb;
	fb_write_t writes_due[$];
	int        mismatches;
	bit        steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic logic [9:0] layout(input int pos, input int size);
		return {5'(size), 5'(pos)};
	endfunction

	function automatic logic [31:0] scale_channel(input logic [7:0] v, input logic [9:0] lay);
		logic [4:0]  pos;
		logic [4:0]  size;
		logic [31:0] maxv;
		logic [31:0] scaled;
		logic [63:0] placed;
		pos = lay[4:0];
		size = lay[9:5];
		if (size > 5'd16)
			size = 5'd16;
		maxv = (32'd1 << size) - 32'd1;
		scaled = (32'(v) * maxv + 32'd127) / 32'd255;
		placed = 64'(scaled) << pos;
		return placed[31:0];
	endfunction

	function automatic fb_write_t predict_write(input pixel_req_t r);
		fb_write_t  w;
		logic [2:0] nb;
		logic [63:0] off;
		if (r.packed_given)
			w.color = r.packed_color;
		else
			w.color = scale_channel(r.red, fb.red) | scale_channel(r.green, fb.green)
				| scale_channel(r.blue, fb.blue);
		nb = fb.pbytes;
		if (nb < 3'd2)
			nb = 3'd2;
		if (nb > 3'd4)
			nb = 3'd4;
		w.on_screen = (32'(r.x) < 32'(fb.width)) && (32'(r.y) < 32'(fb.height));
		w.back = 1'b0;
		w.offset = '0;
		w.data = '0;
		w.be = '0;
		if (w.on_screen) begin
			w.back = fb.dbuf;
			off = 64'(r.y) * 64'(fb.pitch) + 64'(r.x) * 64'(nb);
			w.offset = off[26:0];
			case (nb)
				3'd4: begin
					w.data = w.color;
					w.be = BE_FOUR;
				end
				3'd3: begin
					w.data = {8'h00, w.color[23:0]};
					w.be = BE_THREE;
				end
				default: begin
					w.data = {16'h0000, w.color[15:0]};
					w.be = BE_TWO;
				end
			endcase
		end
		return w;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// accepted requests become expectations, accepted words are checked in order
	always @(posedge clk) begin
		pixel_req_t r;
		fb_write_t  w;
		if (arst_n && pix_in.valid && pix_in.ready) begin
			r.x = pix_in.x_pos;
			r.y = pix_in.y_pos;
			r.packed_given = pix_in.packed_given;
			r.packed_color = pix_in.packed_color;
			r.red = pix_in.red_in;
			r.green = pix_in.green_in;
			r.blue = pix_in.blue_in;
			writes_due.push_back(predict_write(r));
		end
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (writes_due.size() == 0) begin
				$error("write word with nothing expected");
				mismatches++;
			end else begin
				w = writes_due.pop_front();
				check_field("inside_res", 32'(w.on_screen), 32'(pix_out.inside_res));
				check_field("to_back_buffer", 32'(w.back), 32'(pix_out.to_back_buffer));
				check_field("byte_offset", 32'(w.offset), 32'(pix_out.byte_offset));
				check_field("write_data", w.data, pix_out.write_data);
				check_field("byte_enable", 32'(w.be), 32'(pix_out.byte_enable));
				check_field("pixel_color", w.color, pix_out.pixel_color);
			end
		end
	end

	always @(posedge clk)
		pix_out.ready <= steady || ($urandom_range(99) >= 36);

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ACTIVE_WIDTH:  fb.width = val[12:0];
			REG_ACTIVE_HEIGHT: fb.height = val[12:0];
			REG_ROW_PITCH:     fb.pitch = val[14:0];
			REG_PIXEL_BYTES:   fb.pbytes = val[2:0];
			REG_RED_LAYOUT:    fb.red = val[9:0];
			REG_GREEN_LAYOUT:  fb.green = val[9:0];
			REG_BLUE_LAYOUT:   fb.blue = val[9:0];
			REG_DOUBLE_BUF:    fb.dbuf = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// only called while nothing is in flight
	task automatic set_config(input fb_cfg_t c);
		write_reg(REG_ACTIVE_WIDTH, CfgW'(c.width));
		write_reg(REG_ACTIVE_HEIGHT, CfgW'(c.height));
		write_reg(REG_ROW_PITCH, CfgW'(c.pitch));
		write_reg(REG_PIXEL_BYTES, CfgW'(c.pbytes));
		write_reg(REG_RED_LAYOUT, CfgW'(c.red));
		write_reg(REG_GREEN_LAYOUT, CfgW'(c.green));
		write_reg(REG_BLUE_LAYOUT, CfgW'(c.blue));
		write_reg(REG_DOUBLE_BUF, CfgW'(c.dbuf));
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(input pixel_req_t r);
		if (!steady && $urandom_range(99) < 22) begin
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.x_pos <= r.x;
		pix_in.y_pos <= r.y;
		pix_in.packed_given <= r.packed_given;
		pix_in.packed_color <= r.packed_color;
		pix_in.red_in <= r.red;
		pix_in.green_in <= r.green;
		pix_in.blue_in <= r.blue;
		do
			@(posedge clk);
		while (!pix_in.ready);
	endtask

	task automatic drain;
		pix_in.valid <= 1'b0;
		while (writes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic pixel_req_t make_req(input int x, input int y, input bit pg,
		input logic [31:0] pc, input int r, input int g, input int b);
		pixel_req_t q;
		q.x = 16'(x);
		q.y = 16'(y);
		q.packed_given = pg;
		q.packed_color = pc;
		q.red = 8'(r);
		q.green = 8'(g);
		q.blue = 8'(b);
		return q;
	endfunction

	function automatic logic [15:0] random_coord(input logic [12:0] lim);
		int k;
		k = $urandom_range(99);
		if (lim == 0 || k < 10)
			return 16'($urandom);
		if (k < 15)
			return 16'(lim);
		if (k < 22)
			return 16'(lim - 1);
		return 16'($urandom_range(32'(lim) - 1));
	endfunction

	function automatic logic [7:0] random_level;
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pixel_req_t random_pixel;
		pixel_req_t q;
		q.x = random_coord(fb.width);
		q.y = random_coord(fb.height);
		q.packed_given = ($urandom_range(99) < 30);
		q.packed_color = $urandom;
		q.red = random_level();
		q.green = random_level();
		q.blue = random_level();
		return q;
	endfunction

	function automatic logic [12:0] random_dim;
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'h1FFF;
			2: return 13'($urandom_range(1, 16));
			default: return 13'($urandom_range(1, 8191));
		endcase
	endfunction

	function automatic fb_cfg_t random_config;
		fb_cfg_t c;
		c.width = random_dim();
		c.height = random_dim();
		c.pitch = ($urandom_range(9) == 0) ? 15'h7FFF : 15'($urandom_range(0, 32767));
		c.pbytes = ($urandom_range(99) < 70) ? 3'($urandom_range(2, 4)) : 3'($urandom_range(7));
		c.red = 10'($urandom_range(1023));
		c.green = 10'($urandom_range(1023));
		c.blue = 10'($urandom_range(1023));
		c.dbuf = 1'($urandom_range(1));
		return c;
	endfunction

	// reset values: zero size, so every pixel is clipped
	task automatic test_clipped_after_reset;
		send_pixel(make_req(0, 0, 1'b1, 32'hFFFF_FFFF, 0, 0, 0));
		send_pixel(make_req(0, 0, 1'b0, 32'h0, 255, 255, 255));
		send_pixel(make_req(65535, 65535, 1'b1, 32'h1234_5678, 0, 0, 0));
		send_pixel(make_req(1, 1, 1'b0, 32'hFFFF_FFFF, 128, 1, 254));
		drain();
	endtask

	task automatic test_rgb565_edges;
		fb_cfg_t c;
		c = '{width: 13'd640, height: 13'd480, pitch: 15'd1280, pbytes: PB_TWO,
			red: layout(11, 5), green: layout(5, 6), blue: layout(0, 5), dbuf: 1'b0};
		set_config(c);
		send_pixel(make_req(0, 0, 1'b0, 32'h0, 0, 0, 0));
		send_pixel(make_req(639, 479, 1'b0, 32'h0, 255, 255, 255));
		send_pixel(make_req(640, 0, 1'b0, 32'h0, 255, 0, 128));
		send_pixel(make_req(0, 480, 1'b0, 32'h0, 1, 127, 128));
		send_pixel(make_req(320, 240, 1'b1, 32'hFFFF_FFFF, 0, 0, 0));
		send_pixel(make_req(65535, 65535, 1'b1, 32'hA5A5_5A5A, 0, 0, 0));
		send_pixel(make_req(639, 0, 1'b0, 32'h0, 254, 2, 129));
		send_pixel(make_req(0, 479, 1'b1, 32'h0, 255, 255, 255));
		drain();
	endtask

	// mask size clamp, zero size, shift past bit 31 and offset wrap
	task automatic test_layout_extremes;
		fb_cfg_t c;
		c = '{width: 13'h1FFF, height: 13'h1FFF, pitch: 15'h7FFF, pbytes: 3'd7,
			red: layout(31, 31), green: layout(16, 17), blue: layout(0, 0), dbuf: 1'b1};
		set_config(c);
		send_pixel(make_req(8190, 8190, 1'b0, 32'h0, 255, 255, 255));
		send_pixel(make_req(8191, 0, 1'b0, 32'h0, 1, 128, 255));
		send_pixel(make_req(4095, 4095, 1'b0, 32'h0, 129, 1, 0));
		send_pixel(make_req(0, 8190, 1'b1, 32'h8000_0001, 0, 0, 0));
		send_pixel(make_req(8190, 0, 1'b0, 32'h0, 254, 254, 254));
		drain();
	endtask

	// every value of the pixel bytes field, clamped and in range
	task automatic test_pixel_bytes_range;
		fb_cfg_t c;
		c = '{width: 13'd4096, height: 13'd4096, pitch: 15'd16384, pbytes: 3'd0,
			red: layout(16, 8), green: layout(8, 8), blue: layout(0, 8), dbuf: 1'b0};
		for (int pb = 0; pb < 8; pb++) begin
			c.pbytes = 3'(pb);
			c.dbuf = 1'(pb);
			set_config(c);
			send_pixel(make_req(4095 - pb, 4095, pb[0], 32'hDEAD_BEEF, 255, 128, 1));
			drain();
		end
	endtask

	task automatic test_random_phases;
		for (int ph = 0; ph < 10; ph++) begin
			set_config(random_config());
			repeat (180) send_pixel(random_pixel());
			drain();
		end
	endtask

	task automatic test_back_to_back;
		steady = 1'b1;
		set_config(random_config());
		repeat (300) send_pixel(random_pixel());
		drain();
		steady = 1'b0;
	endtask

	initial begin
		mismatches = 0;
		steady = 1'b0;
		fb = '{width: 13'd0, height: 13'd0, pitch: 15'd0, pbytes: PB_FOUR,
			red: 10'd0, green: 10'd0, blue: 10'd0, dbuf: 1'b0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.x_pos = '0;
		pix_in.y_pos = '0;
		pix_in.packed_given = 1'b0;
		pix_in.packed_color = '0;
		pix_in.red_in = '0;
		pix_in.green_in = '0;
		pix_in.blue_in = '0;
		pix_out.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clipped_after_reset();
		test_rgb565_edges();
		test_layout_extremes();
		test_pixel_bytes_range();
		test_random_phases();
		test_back_to_back();

		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
sv/rpw_pkg.sv
sv/rpw_if.sv
sv/rpw_chan_scale.sv
sv/rpw_addr_gen.sv
sv/rgb_pack_pixel_writer_core.sv
sv/rpw_checker.sv
sim/tb_top.sv
